>>> rtl/battery_charge_percent_estimator_top_assert.svh
// assertion macros for the battery charge estimator checker
// expects clk and arst_n to be visible where a macro is used
`ifndef BATTERY_CHARGE_PERCENT_ESTIMATOR_TOP_ASSERT_SVH
`define BATTERY_CHARGE_PERCENT_ESTIMATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BCPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BCPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bcpe_pkg.sv
// shared constants and the discharge curve function for the charge estimator
// no dependencies
package bcpe_pkg;

	localparam int unsigned AVERAGE_COUNT = 50;

	localparam int unsigned SAMPLE_W  = 11;
	localparam int unsigned PERCENT_W = 7;
	localparam int unsigned MV_W      = 13;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned AVG_W     = 10;

	// batch sum magnitude and signed width
	localparam int unsigned MAG_W = $clog2(AVERAGE_COUNT * 1024 + 1);
	localparam int unsigned SUM_W = MAG_W + 1;

	// reciprocal for the batch average
	localparam int unsigned RECIP_SHIFT = MAG_W + COUNT_W;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
	localparam int unsigned PROD_W = MAG_W + RECIP_W;

	// millivolt scaling: avg * 7200 / 1024 = avg * 225 / 32
	localparam int unsigned MV_SCALE = 225;
	localparam int unsigned MV_SHIFT = 5;
	localparam int unsigned SCALED_W = AVG_W + 8;

	// curve segment reciprocals
	localparam int unsigned CURVE_SHIFT = 13;
	localparam int unsigned DIFF_W      = 8;
	localparam int unsigned CPROD_W     = DIFF_W + CURVE_SHIFT;
	localparam logic [CURVE_SHIFT-1:0] RCP_2  = CURVE_SHIFT'(((2**CURVE_SHIFT) + 1) / 2);
	localparam logic [CURVE_SHIFT-1:0] RCP_3  = CURVE_SHIFT'(((2**CURVE_SHIFT) + 2) / 3);
	localparam logic [CURVE_SHIFT-1:0] RCP_4  = CURVE_SHIFT'(((2**CURVE_SHIFT) + 3) / 4);
	localparam logic [CURVE_SHIFT-1:0] RCP_5  = CURVE_SHIFT'(((2**CURVE_SHIFT) + 4) / 5);
	localparam logic [CURVE_SHIFT-1:0] RCP_6  = CURVE_SHIFT'(((2**CURVE_SHIFT) + 5) / 6);
	localparam logic [CURVE_SHIFT-1:0] RCP_7  = CURVE_SHIFT'(((2**CURVE_SHIFT) + 6) / 7);
	localparam logic [CURVE_SHIFT-1:0] RCP_8  = CURVE_SHIFT'(((2**CURVE_SHIFT) + 7) / 8);
	localparam logic [CURVE_SHIFT-1:0] RCP_12 = CURVE_SHIFT'(((2**CURVE_SHIFT) + 11) / 12);
	localparam logic [CURVE_SHIFT-1:0] RCP_18 = CURVE_SHIFT'(((2**CURVE_SHIFT) + 17) / 18);

	function automatic logic [PERCENT_W-1:0] curve_percent(input logic [MV_W-1:0] mv);
		logic [MV_W-1:0]        base;
		logic [PERCENT_W-1:0]   offs;
		logic [CURVE_SHIFT-1:0] rcp;
		logic [DIFF_W-1:0]      diff;
		logic [CPROD_W-1:0]     prod;
		base = '0;
		offs = '0;
		rcp  = '0;
		if (mv >= 13'd4200) begin
			offs = 7'd100;
		end else if (mv >= 13'd4080) begin
			base = 13'd4080; offs = 7'd90; rcp = RCP_12;
		end else if (mv >= 13'd4000) begin
			base = 13'd4000; offs = 7'd80; rcp = RCP_8;
		end else if (mv >= 13'd3930) begin
			base = 13'd3930; offs = 7'd70; rcp = RCP_7;
		end else if (mv >= 13'd3870) begin
			base = 13'd3870; offs = 7'd60; rcp = RCP_6;
		end else if (mv >= 13'd3820) begin
			base = 13'd3820; offs = 7'd50; rcp = RCP_5;
		end else if (mv >= 13'd3790) begin
			base = 13'd3790; offs = 7'd40; rcp = RCP_3;
		end else if (mv >= 13'd3770) begin
			base = 13'd3770; offs = 7'd30; rcp = RCP_2;
		end else if (mv >= 13'd3730) begin
			base = 13'd3730; offs = 7'd20; rcp = RCP_4;
		end else if (mv >= 13'd3700) begin
			base = 13'd3700; offs = 7'd15; rcp = RCP_3;
		end else if (mv >= 13'd3680) begin
			base = 13'd3680; offs = 7'd10; rcp = RCP_2;
		end else if (mv >= 13'd3500) begin
			base = 13'd3500; offs = 7'd5; rcp = RCP_18;
		end
		diff = DIFF_W'(mv - base);
		prod = CPROD_W'(diff) * CPROD_W'(rcp);
		return offs + PERCENT_W'(prod[CPROD_W-1:CURVE_SHIFT]);
	endfunction

endpackage

>>> rtl/bcpe_accum.sv
// sample accumulator and batch counter, registers the finished batch sum
// depends on bcpe_pkg
module bcpe_accum (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [bcpe_pkg::SAMPLE_W-1:0] sample,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	output logic                               sum_valid,
	input  logic                               sum_ready,
	output logic signed [bcpe_pkg::SUM_W-1:0]  sum
);
	import bcpe_pkg::*;

	logic signed [SUM_W-1:0] sum_q;
	logic [COUNT_W-1:0]      count_q;
	logic signed [SUM_W-1:0] sum_s1;
	logic                    valid_s1;
	logic signed [SUM_W-1:0] sum_next;
	logic                    last;
	logic                    accept;

	assign sum_next     = sum_q + SUM_W'(sample);
	assign last         = ({1'b0, count_q} + 9'd1) == 9'(AVERAGE_COUNT);
	assign sample_stall = valid_s1 && !sum_ready;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (last) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_q + COUNT_W'(1);
				end
			end
			if (!valid_s1 || sum_ready) begin
				valid_s1 <= accept && last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			sum_s1 <= sum_next;
		end
	end

	assign sum_valid = valid_s1;
	assign sum       = sum_s1;

endmodule

>>> rtl/bcpe_average.sv
// batch average by reciprocal multiply, then scaling to millivolts
// depends on bcpe_pkg
module bcpe_average (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sum_valid,
	output logic                              sum_ready,
	input  logic signed [bcpe_pkg::SUM_W-1:0] sum,
	output logic                              mv_valid,
	input  logic                              mv_ready,
	output logic [bcpe_pkg::MV_W-1:0]         mv
);
	import bcpe_pkg::*;

	logic [MAG_W-1:0]    mag;
	logic [PROD_W-1:0]   prod;
	logic [AVG_W-1:0]    avg_s2;
	logic                valid_s2;
	logic                ready_s2;
	logic [SCALED_W-1:0] scaled;
	logic [MV_W-1:0]     mv_s3;
	logic                valid_s3;
	logic                ready_s3;

	// negative sums report zero
	assign mag  = MAG_W'(sum[SUM_W-1] ? -sum : sum);
	assign prod = PROD_W'(mag) * PROD_W'(RECIP_W'(RECIP));

	assign ready_s3  = !valid_s3 || mv_ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign sum_ready = ready_s2;

	assign scaled = SCALED_W'(avg_s2) * SCALED_W'(MV_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= sum_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && sum_valid) begin
			avg_s2 <= sum[SUM_W-1] ? '0 : prod[RECIP_SHIFT +: AVG_W];
		end
		if (ready_s3 && valid_s2) begin
			mv_s3 <= scaled[MV_SHIFT +: MV_W];
		end
	end

	assign mv_valid = valid_s3;
	assign mv       = mv_s3;

endmodule

>>> rtl/bcpe_curve.sv
// discharge curve lookup and the result register
// depends on bcpe_pkg
module bcpe_curve (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           mv_valid,
	output logic                           mv_ready,
	input  logic [bcpe_pkg::MV_W-1:0]      mv,
	output logic [bcpe_pkg::PERCENT_W-1:0] percent,
	output logic [bcpe_pkg::MV_W-1:0]      millivolts,
	output logic                           result_valid,
	input  logic                           result_stall
);
	import bcpe_pkg::*;

	logic [PERCENT_W-1:0] percent_q;
	logic [MV_W-1:0]      millivolts_q;
	logic                 valid_q;

	assign mv_ready = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (mv_ready) begin
			valid_q <= mv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_ready && mv_valid) begin
			percent_q    <= curve_percent(mv);
			millivolts_q <= mv;
		end
	end

	assign percent      = percent_q;
	assign millivolts   = millivolts_q;
	assign result_valid = valid_q;

endmodule

>>> rtl/battery_charge_percent_estimator_top.sv
// battery charge estimator top level
// depends on bcpe_pkg, bcpe_accum, bcpe_average, bcpe_curve
//
// input channel: sample with sample_valid / sample_stall, one signed converter
// reading per request. output channel: percent and millivolts with
// result_valid / result_stall, one result per batch of AVERAGE_COUNT samples.
// a sample is taken every cycle that sample_stall is low, and the accumulator
// adds one sample per cycle while not stalled. the last sample of a batch
// enters a four stage pipeline (batch sum, average by reciprocal multiply,
// millivolt scaling, curve lookup into the output register).
// a negative average gives 0 percent and 0 mV.
// when result_stall holds, the pipeline fills behind the held result and
// sample_stall rises only once every stage holds a pending batch result.
// reset clears the batch sum and count and empties every stage.
module battery_charge_percent_estimator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [bcpe_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	output logic [bcpe_pkg::PERCENT_W-1:0]       percent,
	output logic [bcpe_pkg::MV_W-1:0]            millivolts,
	output logic                                 result_valid,
	input  logic                                 result_stall
);
	import bcpe_pkg::*;

	logic                    sum_valid;
	logic                    sum_ready;
	logic signed [SUM_W-1:0] sum;
	logic                    mv_valid;
	logic                    mv_ready;
	logic [MV_W-1:0]         mv;

	bcpe_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sum_valid    (sum_valid),
		.sum_ready    (sum_ready),
		.sum          (sum)
	);

	bcpe_average u_average (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum),
		.mv_valid  (mv_valid),
		.mv_ready  (mv_ready),
		.mv        (mv)
	);

	bcpe_curve u_curve (
		.clk          (clk),
		.arst_n       (arst_n),
		.mv_valid     (mv_valid),
		.mv_ready     (mv_ready),
		.mv           (mv),
		.percent      (percent),
		.millivolts   (millivolts),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

>>> rtl/bcpe_checker.sv
// port level checks for the battery charge estimator, bound to the top level
// depends on bcpe_pkg and battery_charge_percent_estimator_top_assert.svh
`include "battery_charge_percent_estimator_top_assert.svh"

module bcpe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           sample_stall,
	input logic [bcpe_pkg::PERCENT_W-1:0] percent,
	input logic [bcpe_pkg::MV_W-1:0]      millivolts,
	input logic                           result_valid,
	input logic                           result_stall
);
	import bcpe_pkg::*;

	`BCPE_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result dropped while stalled")
	`BCPE_ASSERT_NOW(a_stall_source, sample_stall, result_valid && result_stall, "sample stall without a held result")
	`BCPE_ASSERT_NOW(a_percent_range, result_valid, percent <= 7'd100, "percent above 100")
	`BCPE_ASSERT_NOW(a_mv_range, result_valid, millivolts <= 13'd7192, "millivolts out of range")
	`BCPE_ASSERT_NOW(a_curve_floor, result_valid && (percent != 7'd0), millivolts >= 13'd3500, "charge reported below curve floor")

endmodule

bind battery_charge_percent_estimator_top bcpe_checker u_bcpe_checker (.*);

>>> dv/tb_battery_charge_percent_estimator_top.sv
// testbench for the battery charge estimator: batches of converter samples in,
// charge percent and averaged millivolts out, checked against a batch predictor
// depends on bcpe_pkg and battery_charge_percent_estimator_top
module tb_battery_charge_percent_estimator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bcpe_pkg::*;

	typedef struct packed {
		logic [PERCENT_W-1:0] percent;
		logic [MV_W-1:0]      millivolts;
	} charge_reading_t;

	localparam int KNEE_COUNT = 12;
	localparam int KNEE_MV[KNEE_COUNT]  = '{4200, 4080, 4000, 3930, 3870, 3820,
		3790, 3770, 3730, 3700, 3680, 3500};
	localparam int KNEE_PCT[KNEE_COUNT] = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 15, 10, 5};
	localparam int KNEE_DIV[KNEE_COUNT] = '{1, 12, 8, 7, 6, 5, 3, 2, 4, 3, 2, 18};
	localparam int SAMPLE_MIN    = -1024;
	localparam int SAMPLE_MAX    = 1023;
	localparam int RANDOM_ITEMS  = 200;
	localparam int DRAIN_CYCLES  = 10;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic signed [SAMPLE_W-1:0]   sample = '0;
	logic                         sample_valid = 1'b0;
	logic                         sample_stall;
	logic [PERCENT_W-1:0]         percent;
	logic [MV_W-1:0]              millivolts;
	logic                         result_valid;
	logic                         result_stall = 1'b0;

	charge_reading_t charge_expect_q[$];
	int              batch_sum = 0;
	int              batch_len = 0;
	int              mismatches = 0;
	bit              sender_gaps_on = 1'b0;
	bit              receiver_stalls_on = 1'b0;
	int              stall_left = 0;

	battery_charge_percent_estimator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.percent      (percent),
		.millivolts   (millivolts),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	always #5 clk = ~clk;

	function automatic int charge_from_mv(input int mv);
		if (mv >= KNEE_MV[0])
			return KNEE_PCT[0];
		for (int i = 1; i < KNEE_COUNT; i++) begin
			if (mv >= KNEE_MV[i])
				return KNEE_PCT[i] + (mv - KNEE_MV[i]) / KNEE_DIV[i];
		end
		return 0;
	endfunction

	task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s);
		int              avg;
		int              mv;
		charge_reading_t r;
		batch_sum += int'(s);
		batch_len++;
		if (batch_len == int'(AVERAGE_COUNT)) begin
			avg = batch_sum / int'(AVERAGE_COUNT);
			mv  = 0;
			r   = '0;
			if (avg >= 0) begin
				mv = avg * 7200 / 1024;
				r.percent = PERCENT_W'(charge_from_mv(mv));
			end
			r.millivolts = MV_W'(mv);
			charge_expect_q.push_back(r);
			batch_sum = 0;
			batch_len = 0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (!sender_gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sample_near(input int centre, input int spread);
		int v;
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < SAMPLE_MIN)
			v = SAMPLE_MIN;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return SAMPLE_W'(v);
	endfunction

	// one request; the predictor sees it once the handshake completes
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		accumulate_sample(s);
	endtask

	task automatic send_flat_batch(input int value);
		repeat (AVERAGE_COUNT) send_sample(SAMPLE_W'(value));
	endtask

	task automatic pick_idle_modes();
		sender_gaps_on     = $urandom_range(0, 3) != 0;
		receiver_stalls_on = $urandom_range(0, 3) != 0;
	endtask

	task automatic test_saturation_and_negative();
		pick_idle_modes();
		send_flat_batch(SAMPLE_MAX);
		send_flat_batch(SAMPLE_MIN);
		send_flat_batch(0);
		send_flat_batch(-1);
		for (int i = 0; i < int'(AVERAGE_COUNT); i++)
			send_sample(SAMPLE_W'((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN));
	endtask

	task automatic test_truncation();
		pick_idle_modes();
		// remainder just short of one more step in the average
		repeat (AVERAGE_COUNT - 1) send_sample(SAMPLE_W'(560));
		send_sample(SAMPLE_W'(560 + AVERAGE_COUNT - 1));
		// small negative sum whose average rounds toward zero
		repeat (AVERAGE_COUNT - 1) send_sample(SAMPLE_W'(0));
		send_sample(SAMPLE_W'(1 - int'(AVERAGE_COUNT)));
	endtask

	task automatic test_curve_knees();
		int avg;
		for (int i = 0; i < KNEE_COUNT; i++) begin
			pick_idle_modes();
			avg = (KNEE_MV[i] * 32 + 224) / 225;
			send_flat_batch(avg - 1);
			send_flat_batch(avg);
		end
	endtask

	task automatic test_random_batches();
		int sent;
		int kind;
		int centre;
		int spread;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick_idle_modes();
			kind   = $urandom_range(0, 99);
			centre = $urandom_range(470, 620);
			spread = $urandom_range(0, 24);
			if (kind >= 85 && kind < 95)
				centre = -int'($urandom_range(0, 1024)) + 30;
			for (int i = 0; i < int'(AVERAGE_COUNT); i++) begin
				if (kind >= 95)
					send_sample(SAMPLE_W'($urandom));
				else if (kind >= 80 && kind < 85)
					send_sample(sample_near(int'($urandom_range(0, 2047)) - 1024, 0));
				else
					send_sample(sample_near(centre, spread));
			end
			sent += AVERAGE_COUNT;
		end
	endtask

	// result side: random stall and comparison against the oldest expectation
	always @(posedge clk) begin
		charge_reading_t exp_r;
		bit              next_stall;
		if (arst_n && result_valid && !result_stall) begin
			if (charge_expect_q.size() == 0) begin
				$error("unexpected result: percent %0d millivolts %0d", percent, millivolts);
				mismatches++;
			end else begin
				exp_r = charge_expect_q.pop_front();
				if (percent !== exp_r.percent) begin
					$error("percent: expected %0d, got %0d", exp_r.percent, percent);
					mismatches++;
				end
				if (millivolts !== exp_r.millivolts) begin
					$error("millivolts: expected %0d, got %0d", exp_r.millivolts, millivolts);
					mismatches++;
				end
			end
		end
		next_stall = 1'b0;
		if (stall_left > 0) begin
			stall_left--;
			next_stall = 1'b1;
		end else if (receiver_stalls_on && $urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 49) == 0)
				stall_left = $urandom_range(20, 200);
			else
				stall_left = $urandom_range(0, 3);
			next_stall = 1'b1;
		end
		result_stall <= next_stall;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_saturation_and_negative();
		test_truncation();
		test_curve_knees();
		test_random_batches();
		sample_valid <= 1'b0;
		while (charge_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
